[hw/rtl/cct_pkg.sv]
// Shared constants, types and helpers for the cluster chain table manager.
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

  localparam int ENTRIES = 4096;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int ACT_W   = 3;
  localparam int LINK_W  = 16;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 13;

  localparam logic [LINK_W:0]   ENTRIES_X  = (LINK_W + 1)'(ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(ENTRIES - 1);
  localparam logic [LINK_W-1:0] END_MARK   = '1;
  localparam logic [LINK_W-1:0] FIRST_DATA = LINK_W'(2);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;

  localparam logic [ACT_W-1:0] ACT_READ    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FREE    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_BROKEN = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_LINK, S_FREE_CHK, S_RESULT
  } state_t;

  typedef enum logic [1:0] {RD_IN, RD_SCAN, RD_CUR} rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CLEAR, WR_HOST, WR_SCAN_END, WR_LINK, WR_CUR_ZERO
  } wr_sel_t;

  typedef enum logic [1:0] {LK_ZERO, LK_RDATA, LK_SCAN, LK_END} link_sel_t;

  typedef struct packed {
    logic            in_ready;
    logic            rd_en;
    rd_sel_t         rd_sel;
    wr_sel_t         wr_sel;
    logic            clr_inc;
    logic            scan_init;
    logic            scan_inc;
    logic            cur_load_req;
    logic            cur_load_rdata;
    logic            cnt_inc;
    logic            res_load;
    logic [ST_W-1:0] res_status;
    link_sel_t       link_sel;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic             in_accept;
    logic [ACT_W-1:0] act;
    logic             ext;
    logic             req_in_range;
    logic             req_usable;
    logic             rdata_zero;
    logic             rdata_end;
    logic             rdata_usable;
    logic             scan_last;
    logic             clr_last;
    logic             out_free;
  } stat_t;

  // Index usable by allocation and chain walks: 2 .. ENTRIES-1.
  function automatic logic usable(input logic [LINK_W-1:0] v);
    return (v >= FIRST_DATA) && ({1'b0, v} < ENTRIES_X);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cct_req_if.sv]
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
`default_nettype none

interface cct_req_if;
  logic                       valid;
  logic                       ready;
  logic [cct_pkg::ACT_W-1:0]  action;
  logic [cct_pkg::LINK_W-1:0] cluster;
  logic [cct_pkg::LINK_W-1:0] entry_value;
  logic                       extend;

  modport source (output valid, action, cluster, entry_value, extend, input ready);
  modport sink   (input valid, action, cluster, entry_value, extend, output ready);
endinterface

`default_nettype wire

[hw/rtl/cct_rsp_if.sv]
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
`default_nettype none

interface cct_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cct_pkg::ST_W-1:0]   status;
  logic [cct_pkg::LINK_W-1:0] link_value;
  logic [cct_pkg::CNT_W-1:0]  freed_count;

  modport source (output valid, status, link_value, freed_count, input ready);
  modport sink   (input valid, status, link_value, freed_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/cluster_chain_table_manager.sv]
// Cluster chain table manager: FAT16-style link table with request sequencer.
// Sequencing: read, write, advance without extension and range errors go
//   straight from dispatch to the result register; free chain walks the chain
//   one released cluster at a time; allocate and advance with extension search
//   the table for a free entry from index 2 (one table read port).
// Throughput: one request at a time; a new request is taken while the prior
//   result item still waits in the output register.
// Reset: synchronous; a clearing pass then zeroes all ENTRIES (4096) table
//   entries, one per cycle, before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module cluster_chain_table_manager (
  input  wire logic clk,
  input  wire logic rst,
  cct_req_if.sink   req,
  cct_rsp_if.source rsp
);
  import cct_pkg::*;

  // controller <-> datapath
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decodes the action, runs the free search and chain walk,
  // and hands the finished result to the output register.
  cct_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: table memory (one write, one registered read per cycle),
  // walk/search counters and the result registers.
  cct_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

`default_nettype wire

[hw/rtl/cct_ctrl.sv]
// Sequencer for the table manager: decodes requests and steps the datapath.
`timescale 1ns / 1ps
`default_nettype none

module cct_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cct_pkg::stat_t stat,
  output cct_pkg::cmd_t       cmd
);
  import cct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel   = RD_IN;
    cmd.wr_sel   = WR_NONE;
    cmd.link_sel = LK_ZERO;
    cmd.res_status = ST_OK;

    case (state)
      S_CLEAR: begin
        cmd.wr_sel  = WR_CLEAR;
        cmd.clr_inc = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        // read the addressed entry now so dispatch has it at once
        cmd.in_ready = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_IN;
        if (stat.in_accept) begin
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next   = S_RESULT;
        cmd.res_load = 1'b1;
        case (stat.act)
          ACT_READ: begin
            if (stat.req_in_range) begin
              cmd.link_sel = LK_RDATA;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          ACT_WRITE: begin
            if (stat.req_in_range) begin
              cmd.wr_sel = WR_HOST;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          ACT_ALLOC: begin
            cmd.res_load  = 1'b0;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_RD;
          end
          ACT_ADVANCE: begin
            if (!stat.req_usable) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.rdata_end) begin
              cmd.link_sel = LK_END;
              if (stat.ext) begin
                cmd.res_load  = 1'b0;
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN_RD;
              end
            end else begin
              cmd.link_sel = LK_RDATA;
              if (!stat.rdata_usable) begin
                cmd.res_status = ST_BROKEN;
              end
            end
          end
          ACT_FREE: begin
            if (stat.req_usable) begin
              // start entry is already in the read register
              cmd.res_load     = 1'b0;
              cmd.cur_load_req = 1'b1;
              state_next       = S_FREE_CHK;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCAN;
        state_next = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (stat.rdata_zero) begin
          cmd.wr_sel = WR_SCAN_END;
          if (stat.act == ACT_ADVANCE) begin
            state_next = S_LINK;
          end else begin
            cmd.res_load = 1'b1;
            cmd.link_sel = LK_SCAN;
            state_next   = S_RESULT;
          end
        end else if (stat.scan_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOFREE;
          cmd.link_sel   = (stat.act == ACT_ADVANCE) ? LK_END : LK_ZERO;
          state_next     = S_RESULT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end

      S_LINK: begin
        cmd.wr_sel   = WR_LINK;
        cmd.res_load = 1'b1;
        cmd.link_sel = LK_SCAN;
        state_next   = S_RESULT;
      end

      S_FREE_CHK: begin
        if (stat.rdata_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_BROKEN;
          state_next     = S_RESULT;
        end else begin
          cmd.wr_sel         = WR_CUR_ZERO;
          cmd.cnt_inc        = 1'b1;
          cmd.cur_load_rdata = 1'b1;
          if (stat.rdata_end) begin
            cmd.res_load = 1'b1;
            state_next   = S_RESULT;
          end else if (!stat.rdata_usable) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_BROKEN;
            state_next     = S_RESULT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CUR;
            state_next = S_FREE_CHK;
          end
        end
      end

      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/cct_dp.sv]
// Datapath: link table memory, request and walk registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module cct_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  cct_req_if.sink            req,
  cct_rsp_if.source          rsp,
  input  wire cct_pkg::cmd_t cmd,
  output cct_pkg::stat_t     stat
);
  import cct_pkg::*;

  logic [LINK_W-1:0] mem [ENTRIES];

  logic [ACT_W-1:0]  act_q;
  logic [LINK_W-1:0] cluster_q;
  logic [LINK_W-1:0] value_q;
  logic              ext_q;
  logic [LINK_W-1:0] rdata;
  logic [LINK_W-1:0] cur_q;
  logic [ADDR_W-1:0] scan_q;
  logic [ADDR_W-1:0] clr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ST_W-1:0]   res_status;
  logic [LINK_W-1:0] res_link;

  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [LINK_W-1:0] out_link;
  logic [CNT_W-1:0]  out_count;

  logic              accept;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [LINK_W-1:0] wdata;
  logic              we;
  logic [LINK_W-1:0] link_mux;

  assign req.ready = cmd.in_ready;
  assign accept    = req.valid && req.ready;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q     <= req.action;
      cluster_q <= req.cluster;
      value_q   <= req.entry_value;
      ext_q     <= req.extend;
    end
  end

  // table memory, registered read
  always_comb begin
    case (cmd.rd_sel)
      RD_IN:   raddr = req.cluster[ADDR_W-1:0];
      RD_SCAN: raddr = scan_q;
      // walk follows the link just read
      RD_CUR:  raddr = rdata[ADDR_W-1:0];
      default: raddr = req.cluster[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = cluster_q[ADDR_W-1:0];
    wdata = '0;
    case (cmd.wr_sel)
      WR_CLEAR:    waddr = clr_q;
      WR_HOST:     wdata = value_q;
      WR_SCAN_END: begin
        waddr = scan_q;
        wdata = END_MARK;
      end
      WR_LINK:     wdata = LINK_W'(scan_q);
      WR_CUR_ZERO: waddr = cur_q[ADDR_W-1:0];
      default:     we = 1'b0;
    endcase
  end

  // a read of the entry written in the same cycle sees the new value
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  // clear sweep index, free-search index, walk pointer, freed count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q <= '0;
    end else if (cmd.clr_inc) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_q <= FIRST_DATA[ADDR_W-1:0];
    end else if (cmd.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd.cur_load_req) begin
      cur_q <= cluster_q;
    end else if (cmd.cur_load_rdata) begin
      cur_q <= rdata;
    end
    if (accept) begin
      cnt_q <= '0;
    end else if (cmd.cnt_inc && cnt_q != COUNT_MAX) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // result and output register
  always_comb begin
    case (cmd.link_sel)
      LK_RDATA: link_mux = rdata;
      LK_SCAN:  link_mux = LINK_W'(scan_q);
      LK_END:   link_mux = END_MARK;
      default:  link_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_link   <= link_mux;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_link   <= res_link;
      out_count  <= cnt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.link_value  = out_link;
  assign rsp.freed_count = out_count;

  always_comb begin
    stat.in_accept    = accept;
    stat.act          = act_q;
    stat.ext          = ext_q;
    stat.req_in_range = {1'b0, cluster_q} < ENTRIES_X;
    stat.req_usable   = usable(cluster_q);
    stat.rdata_zero   = rdata == '0;
    stat.rdata_end    = rdata == END_MARK;
    stat.rdata_usable = usable(rdata);
    stat.scan_last    = scan_q == LAST_IDX;
    stat.clr_last     = clr_q == LAST_IDX;
    stat.out_free     = !out_valid || rsp.ready;
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten while pending");

  // no table write in the cycle an item is taken
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !we)
    else $error("table write during request capture");

  // only a free chain walk counts released clusters
  a_count_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> act_q == ACT_FREE)
    else $error("freed count advanced outside free chain");

  // a successful free chain always releases the start cluster
  a_free_ok_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_load && act_q == ACT_FREE && cmd.res_status == ST_OK) |=> cnt_q != '0)
    else $error("free chain finished ok with nothing released");

endmodule

`default_nettype wire
